FILE: sv/irn_pkg.sv
// Shared types and constants of the nearest-neighbor image rotator.
package irn_pkg;

  localparam int IDX_W      = 18;            // pixel number width
  localparam int PIX_W      = 32;            // pixel value width
  localparam int DIM_W      = 10;            // destination size width
  localparam int SDIM_W     = 9;             // source size width
  localparam int COEF_W     = 16;            // Q1.14 coefficient width
  localparam int ADDR_W_MAX = 20;            // store address width at the largest store
  localparam int CMP_W      = ADDR_W_MAX + 1;
  localparam int Q_DEPTH    = 4;             // entries in the front-to-back queue
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Q14    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Q14    = 3'd5;

  // Reset values of the registers.
  localparam logic [SDIM_W-1:0] RST_SRC_DIM = 9'd256;
  localparam logic [DIM_W-1:0]  RST_DST_DIM = 10'd256;
  localparam logic [COEF_W-1:0] RST_COS     = 16'd16384;
  localparam logic [COEF_W-1:0] RST_SIN     = 16'd0;

  // Configuration as the datapath sees it, with sizes already fitted and halved.
  typedef struct packed {
    logic [DIM_W-1:0]  dst_w;
    logic [8:0]        dst_w_half;
    logic [8:0]        dst_h_half;
    logic [SDIM_W-1:0] src_w;
    logic [7:0]        src_w_half;
    logic [SDIM_W-1:0] src_h;
    logic [7:0]        src_h_half;
    logic [COEF_W-1:0] cos_q14;
    logic [COEF_W-1:0] sin_q14;
  } irn_cfg_t;

  // What rides along the arithmetic pipeline with each request.
  typedef struct packed {
    logic             is_write;
    logic             wr_ok;
    logic [IDX_W-1:0] index;
    logic [PIX_W-1:0] value;
  } irn_tag_t;

  // One queue entry: a store write or a classified read.
  typedef struct packed {
    logic                  is_write;
    logic                  ok;
    logic [ADDR_W_MAX-1:0] addr;
    logic [PIX_W-1:0]      value;
  } irn_entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } irn_qstat_t;

endpackage

FILE: sv/irn_div.sv
// Pipelined restoring divider: one quotient bit per stage, pixel number by width.
module irn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [irn_pkg::IDX_W-1:0] dividend,
  input  logic [irn_pkg::DIM_W-1:0] divisor,
  input  irn_pkg::irn_tag_t         in_tag,
  output logic                      out_valid,
  output logic [irn_pkg::IDX_W-1:0] quotient,
  output logic [irn_pkg::DIM_W-1:0] remainder,
  output irn_pkg::irn_tag_t         out_tag
);

  localparam int STAGES = irn_pkg::IDX_W;
  localparam int DW     = irn_pkg::DIM_W;
  localparam int NW     = irn_pkg::IDX_W;

  logic              valid_r [STAGES];
  logic [DW-1:0]     rem_r   [STAGES];
  logic [NW-1:0]     dq_r    [STAGES];   // dividend bits shift out, quotient bits shift in
  irn_pkg::irn_tag_t tag_r   [STAGES];

  logic [DW-1:0]     rem_nxt [STAGES];
  logic [NW-1:0]     dq_nxt  [STAGES];

  always_comb begin : stage_math
    logic [DW-1:0] rem_in;
    logic [NW-1:0] dq_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        rem_in = '0;
        dq_in  = dividend;
      end else begin
        rem_in = rem_r[s-1];
        dq_in  = dq_r[s-1];
      end
      trial      = {rem_in, dq_in[NW-1]};
      ge         = (trial >= {1'b0, divisor});
      diff       = trial - {1'b0, divisor};
      rem_nxt[s] = ge ? diff[DW-1:0] : trial[DW-1:0];
      dq_nxt[s]  = {dq_in[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) valid_r[s] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) valid_r[s] <= valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int s = 1; s < STAGES; s++) tag_r[s] <= tag_r[s-1];
      for (int s = 0; s < STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        dq_r[s]  <= dq_nxt[s];
      end
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign quotient  = dq_r[STAGES-1];
  assign remainder = rem_r[STAGES-1];
  assign out_tag   = tag_r[STAGES-1];

endmodule

FILE: sv/irn_front.sv
// Front end: accepts items, splits and rotates request coordinates, classifies them.
module irn_front #(
  parameter int MAX_SRC_PIXELS = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      mode,
  input  logic [irn_pkg::IDX_W-1:0] pixel_index,
  input  logic [irn_pkg::PIX_W-1:0] pixel_value,
  input  irn_pkg::irn_cfg_t         cfg,
  output logic                      out_valid,
  output irn_pkg::irn_entry_t       out_entry
);

  localparam int CW = irn_pkg::CMP_W;
  localparam logic [CW-1:0] MAX_LIM = CW'(MAX_SRC_PIXELS);

  irn_pkg::irn_tag_t             in_tag;
  logic                          div_valid;
  logic [irn_pkg::IDX_W-1:0]     quo;
  logic [irn_pkg::DIM_W-1:0]     rem;
  irn_pkg::irn_tag_t             div_tag;

  always_comb begin
    in_tag.is_write = !mode;
    in_tag.wr_ok    = ({{(CW-irn_pkg::IDX_W){1'b0}}, pixel_index} < MAX_LIM);
    in_tag.index    = pixel_index;
    in_tag.value    = pixel_value;
  end

  irn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  (pixel_index),
    .divisor   (cfg.dst_w),
    .in_tag    (in_tag),
    .out_valid (div_valid),
    .quotient  (quo),
    .remainder (rem),
    .out_tag   (div_tag)
  );

  logic signed [15:0] cos_s;
  logic signed [15:0] sin_s;
  assign cos_s = $signed(cfg.cos_q14);
  assign sin_s = $signed(cfg.sin_q14);

  // Stage A: centered coordinates.
  logic               va_r;
  logic signed [11:0] x_r, x_nxt;
  logic signed [19:0] y_r, y_nxt;
  irn_pkg::irn_tag_t  ta_r;
  assign x_nxt = $signed({2'b00, rem}) - $signed({3'b000, cfg.dst_w_half});
  assign y_nxt = $signed({2'b00, quo}) - $signed({11'b0, cfg.dst_h_half});

  // Stage B: the four products.
  logic               vb_r;
  logic signed [27:0] p_xc_r, p_xc_nxt, p_xs_r, p_xs_nxt;
  logic signed [35:0] p_yc_r, p_yc_nxt, p_ys_r, p_ys_nxt;
  irn_pkg::irn_tag_t  tb_r;
  assign p_xc_nxt = x_r * cos_s;
  assign p_xs_nxt = x_r * sin_s;
  assign p_yc_nxt = y_r * cos_s;
  assign p_ys_nxt = y_r * sin_s;

  // Stage C: rotated sums in Q14.
  logic              vc_r;
  logic [36:0]       sx_r, sx_nxt, sy_r, sy_nxt;
  irn_pkg::irn_tag_t tc_r;
  assign sx_nxt = {{9{p_xc_r[27]}}, p_xc_r} + {p_ys_r[35], p_ys_r};
  assign sy_nxt = {p_yc_r[35], p_yc_r} - {{9{p_xs_r[27]}}, p_xs_r};

  // Stage D: drop the fraction, rounding toward zero.
  logic              vd_r;
  logic [22:0]       xs_r, xs_nxt, ys_r, ys_nxt;
  logic [36:0]       bx, by;
  irn_pkg::irn_tag_t td_r;
  assign bx     = sx_r + {23'b0, {14{sx_r[36]}}};
  assign by     = sy_r + {23'b0, {14{sy_r[36]}}};
  assign xs_nxt = bx[36:14];
  assign ys_nxt = by[36:14];

  // Stage E: uncentered column and row, bounds test.
  logic              ve_r;
  logic              inside_r, inside_nxt;
  logic [8:0]        col_r, row_r;
  logic [23:0]       col, row;
  irn_pkg::irn_tag_t te_r;
  assign col = {xs_r[22], xs_r} + {16'b0, cfg.src_w_half};
  assign row = {ys_r[22], ys_r} + {16'b0, cfg.src_h_half};
  assign inside_nxt = !col[23] && (col < {15'b0, cfg.src_w}) &&
                      !row[23] && (row < {15'b0, cfg.src_h});

  // Stage F: store address and final classification, the queue's push data.
  logic                vf_r;
  irn_pkg::irn_entry_t entry_r, entry_nxt;
  logic [17:0]         prod;
  logic [18:0]         idx;
  logic                rd_ok;
  assign prod  = row_r * cfg.src_w;
  assign idx   = {1'b0, prod} + {10'b0, col_r};
  assign rd_ok = inside_r && ({{(CW-19){1'b0}}, idx} < MAX_LIM);

  always_comb begin
    entry_nxt.is_write = te_r.is_write;
    entry_nxt.ok       = te_r.is_write ? te_r.wr_ok : rd_ok;
    entry_nxt.addr     = te_r.is_write ? {2'b00, te_r.index} : {1'b0, idx};
    entry_nxt.value    = te_r.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      va_r <= div_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      ta_r     <= div_tag;
      p_xc_r   <= p_xc_nxt;
      p_xs_r   <= p_xs_nxt;
      p_yc_r   <= p_yc_nxt;
      p_ys_r   <= p_ys_nxt;
      tb_r     <= ta_r;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      tc_r     <= tb_r;
      xs_r     <= xs_nxt;
      ys_r     <= ys_nxt;
      td_r     <= tc_r;
      inside_r <= inside_nxt;
      col_r    <= col[8:0];
      row_r    <= row[8:0];
      te_r     <= td_r;
      entry_r  <= entry_nxt;
    end
  end

  assign out_valid = vf_r;
  assign out_entry = entry_r;

endmodule

FILE: sv/irn_fifo.sv
// Short queue between the front end and the store side.
module irn_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  irn_pkg::irn_entry_t push_entry,
  input  logic                pop,
  output irn_pkg::irn_qstat_t status,
  output irn_pkg::irn_entry_t head
);

  irn_pkg::irn_entry_t          slot_r [irn_pkg::Q_DEPTH];
  logic [irn_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [irn_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [irn_pkg::Q_CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  assign status.full  = (count_r == irn_pkg::Q_CNT_W'(irn_pkg::Q_DEPTH));
  assign status.valid = (count_r != '0);
  assign head         = slot_r[rd_ptr_r];

endmodule

FILE: sv/irn_back.sv
// Back end: source image store, registered read and the output register.
module irn_back #(
  parameter int MAX_SRC_PIXELS = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  irn_pkg::irn_qstat_t       q_status,
  input  irn_pkg::irn_entry_t       q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [irn_pkg::PIX_W-1:0] out_pixel,
  output logic                      out_inside
);

  localparam int AW = (MAX_SRC_PIXELS > 1) ? $clog2(MAX_SRC_PIXELS) : 1;

  logic [irn_pkg::PIX_W-1:0] mem [MAX_SRC_PIXELS];
  logic [AW-1:0]             addr;

  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_inside_r;
  logic [irn_pkg::PIX_W-1:0] rd_data_r;
  logic                      out_valid_r;
  logic [irn_pkg::PIX_W-1:0] out_pixel_r;
  logic                      out_inside_r;

  logic out_adv;
  logic s1_free;
  logic rd_pop;

  assign addr    = q_head.addr[AW-1:0];
  assign out_adv = !out_valid_r || out_ready;
  assign s1_free = !s1_valid_r || out_adv;
  assign q_pop   = q_status.valid && s1_free;
  assign rd_pop  = q_pop && !q_head.is_write;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) s1_valid_nxt = rd_pop;
  end

  // One port: a pop is either a write or a read, never both.
  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_write && q_head.ok) mem[addr] <= q_head.value;
    if (rd_pop) rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pop) s1_inside_r <= q_head.ok;
    if (out_adv) begin
      out_pixel_r  <= s1_inside_r ? rd_data_r : '0;
      out_inside_r <= s1_inside_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pixel  = out_pixel_r;
  assign out_inside = out_inside_r;

endmodule

FILE: sv/image_rotate_nearest.sv
// Top level of the nearest-neighbor image rotator.
//
// Usage. Source pixels and output requests arrive on the in_ stream. With
// in_tuser low a request writes pixel_value into the image store at
// pixel_index; with in_tuser high it asks for destination pixel pixel_index
// and produces exactly one result on the out_ stream: the sampled source
// pixel in out_tdata and the inside flag in out_tuser (zero pixel, flag low
// when the rotated point falls outside the source image). Writes produce no
// result. Load the whole image before requesting pixels. The cfg_ port sets
// sizes and the Q1.14 cosine and sine; it is always ready. The user must see that
// it is written only while the block is idle; the block itself does not enforce it.
// Throughput is one request per cycle while the queue has room, set by the
// pipelined divider that splits the pixel number into row and column.
// Reset clears the pipeline, the queue and the output register and loads the
// register defaults; the image store keeps no reset value. When the receiver
// stalls, results back up through the output register and the four-entry
// queue, and in_tready drops once the queue is full.
module image_rotate_nearest #(
  parameter int MAX_SRC_PIXELS = 65536,
  parameter int MAX_DST_DIM    = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [55:0]                    in_tdata,   // pixel_index[17:0], pixel_value[49:18], zero
  input  logic                           in_tuser,   // mode
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // out_pixel[31:0]
  output logic                           out_tuser,  // inside_res
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FIT_W = 13;
  localparam logic [FIT_W-1:0] DIM_LIM = FIT_W'(MAX_DST_DIM);

  logic [irn_pkg::SDIM_W-1:0] src_w_r, src_h_r;
  logic [irn_pkg::DIM_W-1:0]  dst_w_r, dst_h_r;
  logic [irn_pkg::COEF_W-1:0] cos_r, sin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= irn_pkg::RST_SRC_DIM;
      src_h_r <= irn_pkg::RST_SRC_DIM;
      dst_w_r <= irn_pkg::RST_DST_DIM;
      dst_h_r <= irn_pkg::RST_DST_DIM;
      cos_r   <= irn_pkg::RST_COS;
      sin_r   <= irn_pkg::RST_SIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        irn_pkg::REG_SRC_WIDTH:  src_w_r <= cfg_data[irn_pkg::SDIM_W-1:0];
        irn_pkg::REG_SRC_HEIGHT: src_h_r <= cfg_data[irn_pkg::SDIM_W-1:0];
        irn_pkg::REG_DST_WIDTH:  dst_w_r <= cfg_data[irn_pkg::DIM_W-1:0];
        irn_pkg::REG_DST_HEIGHT: dst_h_r <= cfg_data[irn_pkg::DIM_W-1:0];
        irn_pkg::REG_COS_Q14:    cos_r   <= cfg_data;
        irn_pkg::REG_SIN_Q14:    sin_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A destination size of zero acts as one, and sizes above the limit saturate.
  function automatic logic [irn_pkg::DIM_W-1:0] fit_dim(input logic [irn_pkg::DIM_W-1:0] d);
    logic [irn_pkg::DIM_W-1:0] r;
    r = d;
    if (d == '0) r = irn_pkg::DIM_W'(1);
    else if ({{(FIT_W-irn_pkg::DIM_W){1'b0}}, d} > DIM_LIM) r = DIM_LIM[irn_pkg::DIM_W-1:0];
    return r;
  endfunction

  logic [irn_pkg::DIM_W-1:0] dst_w_fit, dst_h_fit;
  irn_pkg::irn_cfg_t         cfg;

  always_comb begin
    dst_w_fit      = fit_dim(dst_w_r);
    dst_h_fit      = fit_dim(dst_h_r);
    cfg.dst_w      = dst_w_fit;
    cfg.dst_w_half = dst_w_fit[irn_pkg::DIM_W-1:1];
    cfg.dst_h_half = dst_h_fit[irn_pkg::DIM_W-1:1];
    cfg.src_w      = src_w_r;
    cfg.src_w_half = src_w_r[irn_pkg::SDIM_W-1:1];
    cfg.src_h      = src_h_r;
    cfg.src_h_half = src_h_r[irn_pkg::SDIM_W-1:1];
    cfg.cos_q14    = cos_r;
    cfg.sin_q14    = sin_r;
  end

  // The front pipeline advances whenever the queue has room.
  irn_pkg::irn_qstat_t q_status;
  irn_pkg::irn_entry_t q_head;
  irn_pkg::irn_entry_t f_entry;
  logic                f_valid;
  logic                q_pop;
  logic                en;

  assign en        = !q_status.full;
  assign in_tready = en;

  irn_front #(
    .MAX_SRC_PIXELS (MAX_SRC_PIXELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .mode        (in_tuser),
    .pixel_index (in_tdata[17:0]),
    .pixel_value (in_tdata[49:18]),
    .cfg         (cfg),
    .out_valid   (f_valid),
    .out_entry   (f_entry)
  );

  irn_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid && en),
    .push_entry (f_entry),
    .pop        (q_pop),
    .status     (q_status),
    .head       (q_head)
  );

  irn_back #(
    .MAX_SRC_PIXELS (MAX_SRC_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pixel  (out_tdata),
    .out_inside (out_tuser)
  );

endmodule

FILE: tb/irn_tb_pkg.sv
// Codes shared by the stimulus and the checker of the rotator testbench.
`timescale 1ns / 1ps
package irn_tb_pkg;

  // Request kinds as carried on in_tuser.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Register indexes that map to nothing.
  localparam logic [irn_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [irn_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // Cycles allowed for writes still in the pipeline once all results are in.
  localparam int DRAIN_CYCLES = 40;

endpackage

FILE: tb/irn_checker.sv
// Passive checker that mirrors the rotator and compares every result.
`timescale 1ns / 1ps
module irn_checker
  import irn_pkg::*;
  import irn_tb_pkg::*;
#(
  parameter int MAX_SRC_PIXELS = 65536,
  parameter int MAX_DST_DIM    = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [55:0]           in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_results
);

  localparam longint Q14_ONE = 64'sd1 << 14;

  typedef struct packed {
    logic             in_image;
    logic [PIX_W-1:0] pixel;
  } sample_t;

  logic [PIX_W-1:0]         image_mem [MAX_SRC_PIXELS];
  logic [SDIM_W-1:0]        src_w, src_h;
  logic [DIM_W-1:0]         dst_w, dst_h;
  logic signed [COEF_W-1:0] cos_c, sin_c;
  sample_t                  expected_q [$];

  // A zero size counts as one; oversized destinations saturate.
  function automatic longint fit_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DST_DIM) return MAX_DST_DIM;
    return d;
  endfunction

  // Inverse-maps destination pixel n and samples the nearest source pixel.
  function automatic sample_t sample_rotated(input logic [IDX_W-1:0] n);
    longint w, h, num, x, y, xs, ys, sw, sh, col, row, pos;
    sample_t r;
    w   = fit_dim(dst_w);
    h   = fit_dim(dst_h);
    num = n;
    sw  = src_w;
    sh  = src_h;
    x   = num % w - w / 2;
    y   = num / w - h / 2;
    // Integer division truncates toward zero, as the block does.
    xs  = (x * longint'(cos_c) + y * longint'(sin_c)) / Q14_ONE;
    ys  = (y * longint'(cos_c) - x * longint'(sin_c)) / Q14_ONE;
    col = xs + sw / 2;
    row = ys + sh / 2;
    r   = '0;
    if (col >= 0 && col < sw && row >= 0 && row < sh) begin
      pos = row * sw + col;
      if (pos < MAX_SRC_PIXELS) begin
        r.in_image = 1'b1;
        r.pixel    = image_mem[pos];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t          want;
    int               errs;
    logic [IDX_W-1:0] idx;
    errs = 0;
    if (!rst_n) begin
      src_w = RST_SRC_DIM;
      src_h = RST_SRC_DIM;
      dst_w = RST_DST_DIM;
      dst_h = RST_DST_DIM;
      cos_c = RST_COS;
      sin_c = RST_SIN;
      expected_q.delete();
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: out_pixel=%h inside_res=%b",
                 out_tdata, out_tuser);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata !== want.pixel) begin
            $error("out_pixel mismatch: expected %h, actual %h", want.pixel, out_tdata);
            errs++;
          end
          if (out_tuser !== want.in_image) begin
            $error("inside_res mismatch: expected %b, actual %b", want.in_image, out_tuser);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w = cfg_data[SDIM_W-1:0];
          REG_SRC_HEIGHT: src_h = cfg_data[SDIM_W-1:0];
          REG_DST_WIDTH:  dst_w = cfg_data[DIM_W-1:0];
          REG_DST_HEIGHT: dst_h = cfg_data[DIM_W-1:0];
          REG_COS_Q14:    cos_c = cfg_data;
          REG_SIN_Q14:    sin_c = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        idx = in_tdata[IDX_W-1:0];
        if (in_tuser == MODE_WRITE) begin
          if (idx < MAX_SRC_PIXELS) image_mem[idx] = in_tdata[IDX_W +: PIX_W];
        end else begin
          expected_q.push_back(sample_rotated(idx));
        end
      end
      fail_count      <= fail_count + errs;
      pending_results <= expected_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Stimulus and verdict for the nearest-neighbor image rotator.
`timescale 1ns / 1ps
module tb;
  import irn_pkg::*;
  import irn_tb_pkg::*;

  localparam int SRC_PIXELS = 65536;
  localparam int DST_MAX    = 512;
  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [55:0]           in_tdata   = '0;
  logic                  in_tuser   = MODE_WRITE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  int                    fail_count;
  int                    pending_results;

  // Percent chances of a sender gap and of a receiver stall in any cycle.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Fitted destination size of the current setting. Request numbers are
  // drawn mostly inside this image so that most of them sample real pixels.
  int dst_w_fit = 256;
  int dst_h_fit = 256;

  // Source size and coefficients of the current setting.
  int src_w_cur = 256;
  int src_h_cur = 256;
  int cos_cur   = 16384;
  int sin_cur   = 0;

  // Store entries written so far. A read is sent only once the pixel it
  // samples holds a written value.
  bit written [SRC_PIXELS];

  image_rotate_nearest u_top (.*);

  irn_checker u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver decides each cycle whether to take a result.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Store entry that destination pixel n samples under the current setting,
  // or -1 when the point falls outside the source image or past the store.
  function automatic int source_of(input logic [IDX_W-1:0] n);
    longint w, h, x, y, xs, ys, col, row, pos;
    w   = dst_w_fit;
    h   = dst_h_fit;
    x   = longint'(n) % w - w / 2;
    y   = longint'(n) / w - h / 2;
    xs  = (x * cos_cur + y * sin_cur) / 16384;
    ys  = (y * cos_cur - x * sin_cur) / 16384;
    col = xs + src_w_cur / 2;
    row = ys + src_h_cur / 2;
    if (col < 0 || col >= src_w_cur || row < 0 || row >= src_h_cur) return -1;
    pos = row * src_w_cur + col;
    if (pos >= SRC_PIXELS) return -1;
    return int'(pos);
  endfunction

  // Presents one request and holds it until the block takes it. The valid
  // stays high afterwards, so back-to-back requests never lower and raise it
  // in the same step; a gap, when one is drawn, lowers it first.
  task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                           input logic [PIX_W-1:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'b0, value, idx};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_WRITE && idx < SRC_PIXELS) written[idx] = 1'b1;
  endtask

  // Sends one read. When the pixel it samples was never written, a write of
  // that pixel goes first.
  task automatic read_item(input logic [IDX_W-1:0] idx);
    int pos;
    pos = source_of(idx);
    if (pos >= 0 && !written[pos]) send_item(MODE_WRITE, IDX_W'(pos), $urandom);
    send_item(MODE_READ, idx, $urandom);
  endtask

  // Stops sending and waits until every outstanding result has come back,
  // then gives trailing writes time to leave the pipeline. The first edge
  // lets the checker count the request accepted last.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write. With noise set, bits above the register's width carry
  // random values, which the block has to drop. The valid is left high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input int width, input bit noise);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] junk;
    keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
    junk = noise ? CFG_DATA_W'($urandom) : '0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (value & keep) | (junk & ~keep);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all six registers back to back. With noise set it also writes the
  // two unmapped indexes, which must leave the setting untouched.
  task automatic set_config(input int sw, input int sh, input int dw, input int dh,
                            input logic [COEF_W-1:0] c, input logic [COEF_W-1:0] s,
                            input bit noise);
    logic [DIM_W-1:0] dw_bits;
    logic [DIM_W-1:0] dh_bits;
    write_reg(REG_SRC_WIDTH,  CFG_DATA_W'(sw), SDIM_W, noise);
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(sh), SDIM_W, noise);
    write_reg(REG_DST_WIDTH,  CFG_DATA_W'(dw), DIM_W,  noise);
    write_reg(REG_DST_HEIGHT, CFG_DATA_W'(dh), DIM_W,  noise);
    write_reg(REG_COS_Q14,    c,               COEF_W, noise);
    write_reg(REG_SIN_Q14,    s,               COEF_W, noise);
    if (noise) begin
      write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom), COEF_W, 1'b0);
      write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom), COEF_W, 1'b0);
    end
    cfg_valid <= 1'b0;
    dw_bits   = DIM_W'(dw);
    dh_bits   = DIM_W'(dh);
    dst_w_fit = (dw_bits == '0) ? 1 : (dw_bits > DST_MAX) ? DST_MAX : int'(dw_bits);
    dst_h_fit = (dh_bits == '0) ? 1 : (dh_bits > DST_MAX) ? DST_MAX : int'(dh_bits);
    src_w_cur = int'(SDIM_W'(sw));
    src_h_cur = int'(SDIM_W'(sh));
    cos_cur   = int'($signed(c));
    sin_cur   = int'($signed(s));
  endtask

  // A random request: about a third are pixel writes, the rest are reads.
  // Writes land mostly inside the current source image. One in ten takes a
  // fully random pixel number, which reaches writes past the store and reads
  // far below the destination image.
  task automatic random_item();
    logic [IDX_W-1:0] idx;
    int               area;
    area = src_w_cur * src_h_cur;
    if (area < 1 || area > SRC_PIXELS) area = SRC_PIXELS;
    if ($urandom_range(99, 0) < 30) begin
      idx = ($urandom_range(9, 0) == 0) ? IDX_W'($urandom)
                                       : IDX_W'($urandom_range(area - 1, 0));
      send_item(MODE_WRITE, idx, $urandom);
    end else begin
      idx = ($urandom_range(9, 0) == 0) ? IDX_W'($urandom)
                                       : IDX_W'($urandom_range(dst_w_fit * dst_h_fit - 1, 0));
      read_item(idx);
    end
  endtask

  initial begin
    int               sw, sh, dw, dh;
    real              ang;
    logic [COEF_W-1:0] c, s;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset setting, which maps each destination
    // pixel onto the same source pixel. Writes at and past the end of the
    // store must be dropped; reads cover three corners, the center, the last
    // column, a number just below the image and the largest number.
    send_item(MODE_WRITE, IDX_W'(0),          32'hFFFF_FFFF);
    send_item(MODE_WRITE, IDX_W'(65535),      32'h0000_0000);
    send_item(MODE_WRITE, IDX_W'(65536),      32'h1234_5678);
    send_item(MODE_WRITE, {IDX_W{1'b1}},      32'hA5A5_A5A5);
    send_item(MODE_WRITE, IDX_W'(18'h0AAAA),  32'h5555_5555);
    send_item(MODE_WRITE, IDX_W'(18'h05555),  32'hAAAA_AAAA);
    read_item(IDX_W'(0));
    read_item(IDX_W'(65535));
    read_item(IDX_W'(18'h0AAAA));
    read_item(IDX_W'(18'h05555));
    read_item(IDX_W'(255));
    read_item(IDX_W'(256));
    read_item(IDX_W'(32896));
    read_item(IDX_W'(65536));
    read_item({IDX_W{1'b1}});

    // Each phase changes the setting while the block is idle, then sends
    // random requests under one of four idling patterns. The first phases
    // pin the extremes: half turns and quarter turns, zero and oversized
    // destinations, a zero source size, a source so large that points fall
    // past the store, and the most negative and positive coefficients.
    for (int k = 0; k < PHASES; k++) begin
      settle();
      case (k % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (k)
        0: set_config(256, 1, 1023, 1023, -16'sd16384, 16'sd0, 1'b0);
        1: set_config(1, 256, 0, 0, 16'sd0, 16'sd16384, 1'b0);
        2: set_config(0, 100, 64, 64, 16'sd11585, 16'sd11585, 1'b0);
        3: set_config(511, 511, 512, 512, 16'sd16384, 16'sd0, 1'b1);
        4: set_config(200, 0, 300, 17, 16'h8000, 16'h7FFF, 1'b1);
        5: set_config(256, 256, 512, 512, 16'sd11585, -16'sd11585, 1'b0);
        default: begin
          sw  = ($urandom_range(3, 0) == 0) ? $urandom_range(511, 257) : $urandom_range(256, 1);
          sh  = ($urandom_range(3, 0) == 0) ? $urandom_range(511, 257) : $urandom_range(256, 1);
          dw  = ($urandom_range(5, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(512, 1);
          dh  = ($urandom_range(5, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(512, 1);
          ang = $urandom_range(359, 0) * 3.14159265358979 / 180.0;
          c   = COEF_W'($rtoi($cos(ang) * 16384.0));
          s   = COEF_W'($rtoi($sin(ang) * 16384.0));
          // Now and then the coefficients take any 16-bit value at all.
          if ($urandom_range(3, 0) == 0) begin
            c = COEF_W'($urandom);
            s = COEF_W'($urandom);
          end
          set_config(sw, sh, dw, dh, c, s, k[0]);
        end
      endcase
      for (int i = 0; i < PHASE_REQS; i++) random_item();
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
